// ===== hdl/pta_pkg.sv =====
// pta_pkg: shared types and constants of the pixel tone adjust block
// register indexes, configuration struct, luma weights and pipeline depth
// no dependencies
`default_nettype none

package pta_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_GAIN         = 2'd0,
      REG_PIVOT_OFFSET = 2'd1,
      REG_SATURATION   = 2'd2,
      REG_VIBRANCE     = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic        [15:0] gain;
      logic signed [11:0] pivot_offset;
      logic        [13:0] saturation_factor;
      logic signed [13:0] vibrance_amount;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      gain:              16'd4096,
      pivot_offset:      12'sd0,
      saturation_factor: 14'd4096,
      vibrance_amount:   14'sd0
   };

   // rec.709 luma weights, q0.16
   localparam logic signed [16:0] LUMA_W [3] = '{17'sd13933, 17'sd46871, 17'sd4732};

   // 255 * 16 in 1/16 units
   localparam logic signed [21:0] FULL_SCALE = 22'sd4080;

   // bias 2^21 * 255 keeps the dividend by 255 positive
   localparam logic signed [32:0] DIV_BIAS = 33'sd534773760;
   // ceil(2^38 / 255), exact for dividends below 2^30
   localparam logic [30:0] RECIP_255 = 31'd1077952577;
   // 2^21 - 4096: removes the bias and adds unity vibrance factor
   localparam logic [24:0] FAC_SHIFT = 25'd2093056;

   localparam int NSTAGE = 12;

endpackage

`default_nettype wire

// ===== hdl/pixel_tone_adjust_core.sv =====
// pixel_tone_adjust_core: gain/offset, saturation and vibrance on rgb pixels
// twelve-stage pipeline, depends on pta_pkg and pta_regs
//
//   port group  direction  transfer
//   req_*       in         req_valid high and req_stall low
//   rsp_*       out        rsp_valid high and rsp_stall low
//   apb         in/out     psel, penable and pready high
//
// one pixel per clock while rsp_stall does not back up the pipeline
// twelve register stages, at most one multiply per channel per stage
// reset clears the stage valid bits and loads the default settings
// rsp_stall holds the last stage, earlier stages still fill empty slots
// req_stall rises only when all twelve stages hold a pixel
`default_nettype none

module pixel_tone_adjust_core
   import pta_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_red_in,
   input  wire logic [7:0]            req_green_in,
   input  wire logic [7:0]            req_blue_in,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic signed [15:0]         rsp_red_out,
   output logic signed [15:0]         rsp_green_out,
   output logic signed [15:0]         rsp_blue_out,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   function automatic logic signed [15:0] sat16(input logic signed [34:0] v);
      logic signed [15:0] r;
      if (v > 35'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -35'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   cfg_type cfg;

   pta_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // stage control
   logic [NSTAGE-1:0] v_ff;
   logic [NSTAGE-1:0] v_in;
   logic [NSTAGE-1:0] stage_adv;
   logic              in_xfer;
   logic              out_xfer;

   always_comb begin
      stage_adv[NSTAGE-1] = !v_ff[NSTAGE-1] || !rsp_stall;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         stage_adv[k] = !v_ff[k] || stage_adv[k+1];
      end
      v_in[0] = stage_adv[0] ? req_valid : v_ff[0];
      for (int k = 1; k < NSTAGE; k++) begin
         v_in[k] = stage_adv[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   assign req_stall = !stage_adv[0];
   assign rsp_valid = v_ff[NSTAGE-1];
   assign in_xfer   = req_valid && !req_stall;
   assign out_xfer  = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // datapath registers
   logic        [7:0]  pix [3];
   logic signed [17:0] x1_ff [3], x1_in [3];
   logic signed [34:0] lp2_ff [3], lp2_in [3];
   logic signed [17:0] x2_ff [3];
   logic signed [17:0] l3_ff, l3_in;
   logic signed [17:0] x3_ff [3];
   logic signed [33:0] p4_ff [3], p4_in [3];
   logic signed [17:0] l4_ff;
   logic signed [20:0] y5_ff [3], y5_in [3];
   logic signed [37:0] lq6_ff [3], lq6_in [3];
   logic signed [20:0] y6_ff [3];
   logic signed [21:0] e6_ff, e6_in;
   logic signed [35:0] n7_ff, n7_in;
   logic signed [20:0] l7_ff, l7_in;
   logic signed [20:0] y7_ff [3];
   logic        [29:0] u8_ff, u8_in;
   logic signed [21:0] dy8_ff [3], dy8_in [3];
   logic signed [20:0] l8_ff;
   logic        [22:0] q9_ff, q9_in;
   logic signed [21:0] dy9_ff [3];
   logic signed [20:0] l9_ff;
   logic        [22:0] fac10_ff, fac10_in;
   logic signed [21:0] dy10_ff [3];
   logic signed [20:0] l10_ff;
   logic signed [45:0] pz11_ff [3], pz11_in [3];
   logic signed [20:0] l11_ff;
   logic signed [15:0] out12_ff [3], out12_in [3];

   logic        [24:0] g1_round [3];
   logic signed [36:0] sum3;
   logic signed [18:0] dx4 [3];
   logic signed [33:0] r5 [3];
   logic signed [21:0] y5_wide [3];
   logic signed [20:0] y_max, y_min;
   logic signed [21:0] d6;
   logic signed [39:0] sum7;
   logic signed [36:0] a8;
   logic signed [32:0] m8;
   logic        [60:0] pq9;
   logic signed [24:0] f10;
   logic signed [45:0] r12 [3];
   logic signed [34:0] z12 [3];

   assign pix[0] = req_red_in;
   assign pix[1] = req_green_in;
   assign pix[2] = req_blue_in;

   always_comb begin
      // gain and pivot offset
      for (int c = 0; c < 3; c++) begin
         g1_round[c] = 25'(cfg.gain) * 25'(pix[c]) + 25'd128;
         x1_in[c] = $signed({1'b0, g1_round[c][24:8]})
                  + $signed({{6{cfg.pivot_offset[11]}}, cfg.pivot_offset});
      end
      // luma of x
      for (int c = 0; c < 3; c++) begin
         lp2_in[c] = LUMA_W[c] * x1_ff[c];
      end
      sum3 = {{2{lp2_ff[0][34]}}, lp2_ff[0]} + {{2{lp2_ff[1][34]}}, lp2_ff[1]}
           + {{2{lp2_ff[2][34]}}, lp2_ff[2]} + 37'sd32768;
      l3_in = sum3[33:16];
      // saturation
      for (int c = 0; c < 3; c++) begin
         dx4[c]  = {x3_ff[c][17], x3_ff[c]} - {l3_ff[17], l3_ff};
         p4_in[c] = $signed({1'b0, cfg.saturation_factor}) * dx4[c];
      end
      for (int c = 0; c < 3; c++) begin
         r5[c] = p4_ff[c] + 34'sd2048;
         y5_wide[c] = {{4{l4_ff[17]}}, l4_ff} + r5[c][33:12];
         y5_in[c] = y5_wide[c][20:0];
      end
      // spread and luma of y
      y_max = y5_ff[0];
      y_min = y5_ff[0];
      for (int c = 1; c < 3; c++) begin
         if (y5_ff[c] > y_max) begin
            y_max = y5_ff[c];
         end
         if (y5_ff[c] < y_min) begin
            y_min = y5_ff[c];
         end
      end
      d6 = {y_max[20], y_max} - {y_min[20], y_min};
      e6_in = FULL_SCALE - d6;
      for (int c = 0; c < 3; c++) begin
         lq6_in[c] = LUMA_W[c] * y5_ff[c];
      end
      n7_in = cfg.vibrance_amount * e6_ff;
      sum7 = {{2{lq6_ff[0][37]}}, lq6_ff[0]} + {{2{lq6_ff[1][37]}}, lq6_ff[1]}
           + {{2{lq6_ff[2][37]}}, lq6_ff[2]} + 40'sd32768;
      l7_in = sum7[36:16];
      // vibrance factor: floor((n + 2040) / 4080) as /16 then /255
      a8 = {n7_ff[35], n7_ff} + 37'sd2040;
      m8 = a8[36:4] + DIV_BIAS;
      u8_in = m8[29:0];
      for (int c = 0; c < 3; c++) begin
         dy8_in[c] = {y7_ff[c][20], y7_ff[c]} - {l7_ff[20], l7_ff};
      end
      pq9 = u8_ff * RECIP_255;
      q9_in = pq9[60:38];
      f10 = $signed({2'b00, q9_ff}) - $signed(FAC_SHIFT);
      fac10_in = f10[24] ? 23'd0 : f10[22:0];
      for (int c = 0; c < 3; c++) begin
         pz11_in[c] = $signed({1'b0, fac10_ff}) * dy10_ff[c];
      end
      for (int c = 0; c < 3; c++) begin
         r12[c] = pz11_ff[c] + 46'sd2048;
         z12[c] = {{14{l11_ff[20]}}, l11_ff} + {r12[c][45], r12[c][45:12]};
         out12_in[c] = sat16(z12[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_adv[0]) begin
         x1_ff <= x1_in;
      end
      if (stage_adv[1]) begin
         lp2_ff <= lp2_in;
         x2_ff  <= x1_ff;
      end
      if (stage_adv[2]) begin
         l3_ff <= l3_in;
         x3_ff <= x2_ff;
      end
      if (stage_adv[3]) begin
         p4_ff <= p4_in;
         l4_ff <= l3_ff;
      end
      if (stage_adv[4]) begin
         y5_ff <= y5_in;
      end
      if (stage_adv[5]) begin
         lq6_ff <= lq6_in;
         e6_ff  <= e6_in;
         y6_ff  <= y5_ff;
      end
      if (stage_adv[6]) begin
         n7_ff <= n7_in;
         l7_ff <= l7_in;
         y7_ff <= y6_ff;
      end
      if (stage_adv[7]) begin
         u8_ff  <= u8_in;
         dy8_ff <= dy8_in;
         l8_ff  <= l7_ff;
      end
      if (stage_adv[8]) begin
         q9_ff  <= q9_in;
         dy9_ff <= dy8_ff;
         l9_ff  <= l8_ff;
      end
      if (stage_adv[9]) begin
         fac10_ff <= fac10_in;
         dy10_ff  <= dy9_ff;
         l10_ff   <= l9_ff;
      end
      if (stage_adv[10]) begin
         pz11_ff <= pz11_in;
         l11_ff  <= l10_ff;
      end
      if (stage_adv[11]) begin
         out12_ff <= out12_in;
      end
   end

   assign rsp_red_out   = out12_ff[0];
   assign rsp_green_out = out12_ff[1];
   assign rsp_blue_out  = out12_ff[2];

`ifndef SYNTH
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&v_ff))
      else $error("input stalled with an empty stage");

   a_count: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ($countones(v_ff) == $countones($past(v_ff))
         + $past(in_xfer) - $past(out_xfer)))
      else $error("pixel count in pipeline not conserved");

   a_last_fill: assert property (@(posedge clock) disable iff (reset)
      (v_ff[NSTAGE-2] && stage_adv[NSTAGE-1]) |=> v_ff[NSTAGE-1])
      else $error("pixel lost entering output stage");

   a_first_fill: assert property (@(posedge clock) disable iff (reset)
      in_xfer |=> v_ff[0])
      else $error("accepted pixel not held in first stage");
`endif

endmodule

`default_nettype wire

// ===== hdl/pta_regs.sv =====
// pta_regs: apb-style register file for the tone settings
// depends on pta_pkg
`default_nettype none

module pta_regs
   import pta_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_sel;
   logic          wr_xfer;

   assign reg_sel = reg_index_type'(paddr[3:2]);
   assign wr_xfer = psel && penable && pwrite && pready;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_xfer) begin
         case (reg_sel)
            REG_GAIN:         cfg_in.gain              = pwdata[15:0];
            REG_PIVOT_OFFSET: cfg_in.pivot_offset      = pwdata[11:0];
            REG_SATURATION:   cfg_in.saturation_factor = pwdata[13:0];
            REG_VIBRANCE:     cfg_in.vibrance_amount   = pwdata[13:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_GAIN:         prdata = {16'd0, cfg_ff.gain};
         REG_PIVOT_OFFSET: prdata = {20'd0, cfg_ff.pivot_offset};
         REG_SATURATION:   prdata = {18'd0, cfg_ff.saturation_factor};
         REG_VIBRANCE:     prdata = {18'd0, cfg_ff.vibrance_amount};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== bench/pixel_tone_adjust_checker.sv =====
// pixel_tone_adjust_checker: watches the pixel and register ports of the tone adjust core
// predicts each toned pixel from its own copy of the settings and compares it on transfer
// depends on pta_pkg for the register indexes and the settings struct
`default_nettype none

module pixel_tone_adjust_checker
   import pta_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire logic [7:0]            req_red_in,
   input  wire logic [7:0]            req_green_in,
   input  wire logic [7:0]            req_blue_in,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire logic signed [15:0]    rsp_red_out,
   input  wire logic signed [15:0]    rsp_green_out,
   input  wire logic signed [15:0]    rsp_blue_out,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   input  wire logic [CSR_DATA_W-1:0] prdata,
   input  wire logic                  pready,
   output int                         fail_count,
   output int                         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint WEIGHT_RED   = 13933;
   localparam longint WEIGHT_GREEN = 46871;
   localparam longint WEIGHT_BLUE  = 4732;
   localparam longint SPAN_FULL    = 4080;

   typedef struct packed {
      logic signed [15:0] red;
      logic signed [15:0] green;
      logic signed [15:0] blue;
   } toned_pixel_type;

   cfg_type         settings;
   toned_pixel_type toned_q[$];

   function automatic longint div_floor(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint div_round(longint n, longint d);
      return div_floor(2 * n + d, 2 * d);
   endfunction

   function automatic longint luma_of(longint r, longint g, longint b);
      return div_round(WEIGHT_RED * r + WEIGHT_GREEN * g + WEIGHT_BLUE * b, 65536);
   endfunction

   function automatic logic signed [15:0] clip16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic toned_pixel_type tone_map(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                                cfg_type c);
      longint          v [3];
      longint          x [3];
      longint          y [3];
      longint          gain_l, offset_l, sat_l, vib_l, l, mx, mn, q, fac;
      toned_pixel_type t;
      gain_l   = longint'(c.gain);
      offset_l = longint'(c.pivot_offset);
      sat_l    = longint'(c.saturation_factor);
      vib_l    = longint'(c.vibrance_amount);
      v[0] = longint'(r);
      v[1] = longint'(g);
      v[2] = longint'(b);
      for (int i = 0; i < 3; i++) x[i] = div_round(gain_l * v[i], 256) + offset_l;
      l = luma_of(x[0], x[1], x[2]);
      for (int i = 0; i < 3; i++) y[i] = l + div_round(sat_l * (x[i] - l), 4096);
      mx = y[0];
      mn = y[0];
      for (int i = 1; i < 3; i++) begin
         if (y[i] > mx) mx = y[i];
         if (y[i] < mn) mn = y[i];
      end
      q   = div_round(vib_l * (SPAN_FULL - (mx - mn)), SPAN_FULL);
      fac = 4096 + q;
      if (fac < 0) fac = 0;
      l = luma_of(y[0], y[1], y[2]);
      t.red   = clip16(l + div_round(fac * (y[0] - l), 4096));
      t.green = clip16(l + div_round(fac * (y[1] - l), 4096));
      t.blue  = clip16(l + div_round(fac * (y[2] - l), 4096));
      return t;
   endfunction

   function automatic int channel_errs(string name, logic signed [15:0] want,
                                       logic signed [15:0] got);
      if (want === got) return 0;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      toned_pixel_type want;
      logic [31:0]     reg_want;
      logic [31:0]     reg_mask;
      int              errs;
      errs = 0;
      if (reset) begin
         settings <= CFG_RESET;
         toned_q.delete();
         pending_count <= 0;
         fail_count    <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[CSR_ADDR_W-1:2]))
               REG_GAIN:         settings.gain              <= pwdata[15:0];
               REG_PIVOT_OFFSET: settings.pivot_offset      <= pwdata[11:0];
               REG_SATURATION:   settings.saturation_factor <= pwdata[13:0];
               REG_VIBRANCE:     settings.vibrance_amount   <= pwdata[13:0];
               default: ;
            endcase
         end
         if (psel && penable && !pwrite && pready) begin
            case (reg_index_type'(paddr[CSR_ADDR_W-1:2]))
               REG_GAIN: begin
                  reg_want = {16'd0, settings.gain};
                  reg_mask = 32'h0000ffff;
               end
               REG_PIVOT_OFFSET: begin
                  reg_want = {20'd0, settings.pivot_offset};
                  reg_mask = 32'h00000fff;
               end
               REG_SATURATION: begin
                  reg_want = {18'd0, settings.saturation_factor};
                  reg_mask = 32'h00003fff;
               end
               default: begin
                  reg_want = {18'd0, settings.vibrance_amount};
                  reg_mask = 32'h00003fff;
               end
            endcase
            if ((prdata & reg_mask) !== reg_want) begin
               $display("%0t: register at 0x%0h expected 0x%0h got 0x%0h", $time, paddr,
                        reg_want, prdata & reg_mask);
               errs++;
            end
         end
         if (req_valid && !req_stall)
            toned_q.push_back(tone_map(req_red_in, req_green_in, req_blue_in, settings));
         if (rsp_valid && !rsp_stall) begin
            if (toned_q.size() == 0) begin
               $display("%0t: unexpected transfer expected none got %0d %0d %0d", $time,
                        rsp_red_out, rsp_green_out, rsp_blue_out);
               errs++;
            end else begin
               want = toned_q.pop_front();
               errs += channel_errs("red_out", want.red, rsp_red_out);
               errs += channel_errs("green_out", want.green, rsp_green_out);
               errs += channel_errs("blue_out", want.blue, rsp_blue_out);
            end
         end
         pending_count <= toned_q.size();
         fail_count    <= fail_count + errs;
      end
   end

endmodule

`default_nettype wire

// ===== bench/pixel_tone_adjust_core_tb.sv =====
// pixel_tone_adjust_core_tb: stimulus and verdict for the pixel tone adjust core
// drives pixels and register settings with random gaps, the checker does the comparing
// depends on pta_pkg, pixel_tone_adjust_core and pixel_tone_adjust_checker
`default_nettype none

module pixel_tone_adjust_core_tb
   import pta_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASES      = 16;
   localparam int PHASE_ITEMS = 105;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [7:0]            req_red_in;
   logic [7:0]            req_green_in;
   logic [7:0]            req_blue_in;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic signed [15:0]    rsp_red_out;
   logic signed [15:0]    rsp_green_out;
   logic signed [15:0]    rsp_blue_out;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    fail_count;
   int                    pending_count;
   int                    gap_mode;
   int                    stall_mode;
   int                    stall_hold;

   pixel_tone_adjust_core uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   pixel_tone_adjust_checker tone_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      int pick;
      if (reset || stall_mode == 0) begin
         rsp_stall <= 1'b0;
      end else if (stall_hold > 0) begin
         stall_hold = stall_hold - 1;
         rsp_stall <= 1'b1;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            rsp_stall <= 1'b0;
         end else if (pick < 95) begin
            rsp_stall <= 1'b1;
         end else if (pick < 99) begin
            stall_hold = $urandom_range(2, 8);
            rsp_stall <= 1'b1;
         end else begin
            stall_hold = $urandom_range(20, 60);
            rsp_stall <= 1'b1;
         end
      end
   end

   function automatic int pick_gap();
      int pick;
      if (gap_mode == 0) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int gap;
      @(negedge clock);
      req_valid    <= 1'b1;
      req_red_in   <= r;
      req_green_in <= g;
      req_blue_in  <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic csr_access(reg_index_type idx, logic write_en, logic [31:0] word);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write_en;
      paddr   <= {idx, 2'b00};
      pwdata  <= word;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic read_back_all();
      for (int i = 0; i < 4; i++) csr_access(reg_index_type'(i), 1'b0, 32'd0);
   endtask

   task automatic apply_settings(logic [15:0] g, logic [11:0] po, logic [13:0] s,
                                 logic [13:0] v);
      logic [31:0] word;
      word = $urandom;
      word[15:0] = g;
      csr_access(REG_GAIN, 1'b1, word);
      word = $urandom;
      word[11:0] = po;
      csr_access(REG_PIVOT_OFFSET, 1'b1, word);
      word = $urandom;
      word[13:0] = s;
      csr_access(REG_SATURATION, 1'b1, word);
      word = $urandom;
      word[13:0] = v;
      csr_access(REG_VIBRANCE, 1'b1, word);
      read_back_all();
   endtask

   task automatic run_phase(int phase);
      logic [15:0] g;
      logic [11:0] po;
      logic [13:0] s;
      logic [13:0] v;
      logic [7:0]  r, gr, b;
      int          kind;
      case ($urandom_range(0, 4))
         0: g = 16'd0;
         1: g = 16'hffff;
         2: g = 16'd4096;
         3: g = 16'($urandom_range(2048, 8192));
         default: g = 16'($urandom);
      endcase
      case ($urandom_range(0, 3))
         0: po = 12'h800;
         1: po = 12'h7ff;
         2: po = 12'h000;
         default: po = 12'($urandom);
      endcase
      case ($urandom_range(0, 4))
         0: s = 14'd0;
         1: s = 14'h3fff;
         2: s = 14'd4096;
         3: s = 14'd8192;
         default: s = 14'($urandom);
      endcase
      case ($urandom_range(0, 5))
         0: v = 14'h2000;
         1: v = 14'h1fff;
         2: v = 14'h1000;
         3: v = 14'h3000;
         4: v = 14'h0000;
         default: v = 14'($urandom);
      endcase
      apply_settings(g, po, s, v);
      gap_mode   = (phase % 4 == 0) ? 0 : 1;
      stall_mode = (phase % 4 == 0) ? 0 : 1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if (phase % 3 == 1 && i == PHASE_ITEMS / 2) wait_drain();
         kind = $urandom_range(0, 9);
         r  = 8'($urandom);
         gr = 8'($urandom);
         b  = 8'($urandom);
         if (kind == 0) begin
            gr = r;
            b  = r;
         end else if (kind == 1) begin
            r  = {8{r[0]}};
            gr = {8{gr[0]}};
            b  = {8{b[0]}};
         end
         send_pixel(r, gr, b);
      end
      wait_drain();
   endtask

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_red_in   = 8'd0;
      req_green_in = 8'd0;
      req_blue_in  = 8'd0;
      rsp_stall    = 1'b0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      gap_mode     = 0;
      stall_mode   = 0;
      stall_hold   = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // reset settings give the identity, with outputs in 1/16 units
      read_back_all();
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd128, 8'd64, 8'd32);
      send_pixel(8'h55, 8'haa, 8'h55);
      send_pixel(8'haa, 8'h55, 8'haa);
      wait_drain();

      // top of gain, offset and saturation, most negative vibrance, some outputs clip
      apply_settings(16'hffff, 12'h7ff, 14'h3fff, 14'h2000);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      wait_drain();

      // bottom of gain, offset and saturation, top vibrance, outputs go negative
      apply_settings(16'd0, 12'h800, 14'd0, 14'h1fff);
      send_pixel(8'd255, 8'd128, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      wait_drain();

      // spread beyond full scale drives the vibrance factor below zero
      apply_settings(16'hffff, 12'h000, 14'd4096, 14'h1000);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd40, 8'd200, 8'd90);
      wait_drain();

      for (int p = 0; p < PHASES; p++) run_phase(p);

      wait_drain();
      repeat (3 * NSTAGE) @(posedge clock);
      if (pending_count != 0) $display("%0t: %0d transfers never arrived", $time,
                                       pending_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/pta_pkg.sv
hdl/pta_regs.sv
hdl/pixel_tone_adjust_core.sv
bench/pixel_tone_adjust_checker.sv
bench/pixel_tone_adjust_core_tb.sv
